// ===== sv/wvir_pkg.sv =====
// ---------------------------------------------------------------------------
// Wavetable voice package
// Shared types and constants for the interpolating wavetable voice.
// ---------------------------------------------------------------------------
package wvir_pkg;

   localparam int FRAC_BITS      = 10;
   localparam int ONE_FIX        = 1024;
   localparam int VOL_DIV        = 102400;
   localparam int VOL_RECIP      = 5243;
   localparam int VOL_RECIP_SH   = 19;
   localparam int WAVE_DEPTH_DEF = 16384;

   localparam int POS_W   = 26;
   localparam int CNT_W   = 24;
   localparam int CSR_W   = 24;
   localparam int DIV_R_W = 25;
   localparam int DIV_Q_W = 10;
   localparam int DIV_S_W = 4;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [2:0] CSR_STEP        = 3'd0;
   localparam logic [2:0] CSR_VOLUME      = 3'd1;
   localparam logic [2:0] CSR_SUSTAIN_LEN = 3'd2;
   localparam logic [2:0] CSR_RELEASE_LEN = 3'd3;
   localparam logic [2:0] CSR_RELEASE_END = 3'd4;
   localparam logic [2:0] CSR_SAMPLE_LEN  = 3'd5;

   typedef struct packed {
      logic [1:0]        kind;
      logic [13:0]       addr;
      logic signed [7:0] byte_req;
   } req_type;

   typedef struct packed {
      logic signed [7:0] sample;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_R_W-1:0]   rem_init;
      logic [DIV_Q_W-1:0]   low_bits;
      logic [DIV_R_W-1:0]   divisor;
      logic [DIV_S_W-1:0]   steps;
   } div_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic [DIV_Q_W-1:0]   quot;
   } div_stat_type;

endpackage

// ===== sv/wvir_wave_ram.sv =====
// ---------------------------------------------------------------------------
// Wavetable byte memory
// Single write port and single registered read port holding signed bytes.
// ---------------------------------------------------------------------------
module wvir_wave_ram #(
   parameter int DEPTH = wvir_pkg::WAVE_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wvir_div_unit.sv =====
// ---------------------------------------------------------------------------
// Serial divider
// Restoring divider producing one quotient bit per cycle from a partial
// remainder that starts below the divisor.
// ---------------------------------------------------------------------------
module wvir_div_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  wvir_pkg::div_cmd_type  cmd,
   output wvir_pkg::div_stat_type stat
);

   logic [wvir_pkg::DIV_R_W-1:0] rem_ff, rem_in;
   logic [wvir_pkg::DIV_R_W-1:0] dvs_ff, dvs_in;
   logic [wvir_pkg::DIV_Q_W-1:0] sh_ff, sh_in;
   logic [wvir_pkg::DIV_Q_W-1:0] q_ff, q_in;
   logic [wvir_pkg::DIV_S_W-1:0] cnt_ff, cnt_in;
   logic [wvir_pkg::DIV_R_W:0]   trial;
   logic                         fits;

   assign trial = {rem_ff, sh_ff[wvir_pkg::DIV_Q_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      sh_in  = sh_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         rem_in = cmd.rem_init;
         dvs_in = cmd.divisor;
         sh_in  = cmd.low_bits;
         q_in   = '0;
         cnt_in = cmd.steps;
      end else if (cnt_ff != '0) begin
         rem_in = fits ? wvir_pkg::DIV_R_W'(trial - {1'b0, dvs_ff})
                       : trial[wvir_pkg::DIV_R_W-1:0];
         sh_in  = {sh_ff[wvir_pkg::DIV_Q_W-2:0], 1'b0};
         q_in   = {q_ff[wvir_pkg::DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

   assign stat.busy = cnt_ff != '0;
   assign stat.quot = q_ff;

endmodule

// ===== sv/wavetable_voice_interp_release.sv =====
// ---------------------------------------------------------------------------
// Wavetable voice with linear interpolation and release fade
// Usage:
// Requests arrive on req_valid/req_ready with a req_payload of kind, addr
// and byte_req. A write request stores one byte in the wavetable, a start
// request rewinds the voice, and a tick on an active voice produces one
// sample transfer on rsp_valid/rsp_ready carrying the sample and a last flag.
// A producing tick runs through the read, mix, scale and volume states, FADE
// past the sustain (zero fade factor after the release, else FWAIT while the
// serial divider works out the fade factor), then APPLY and DONE into the
// output register. Volume division is a reciprocal multiplication. The block
// takes one request at a time; req_ready is high only while the sequencer is
// idle. A finished sample sits in the output register while new requests are
// taken; a tick that finishes while the receiver still stalls waits until
// that register frees. Synchronous reset clears the voice to idle and loads
// the register defaults; wavetable contents are kept. Configuration writes on
// csr_we take effect at once; the user must make them only idle (not enforced).
// ---------------------------------------------------------------------------
module wavetable_voice_interp_release #(
   parameter int WAVE_DEPTH = wvir_pkg::WAVE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  wvir_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output wvir_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [wvir_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int AW = $clog2(WAVE_DEPTH);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_RDA   = 11'b00000000010,
      ST_RDB   = 11'b00000000100,
      ST_MIX   = 11'b00000001000,
      ST_SCALE = 11'b00000010000,
      ST_VSTRT = 11'b00000100000,
      ST_VWAIT = 11'b00001000000,
      ST_FADE  = 11'b00010000000,
      ST_FWAIT = 11'b00100000000,
      ST_APPLY = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] step_ff, step_in;
   logic [7:0]  volume_ff, volume_in;
   logic [23:0] sustain_ff, sustain_in;
   logic [23:0] rel_len_ff, rel_len_in;
   logic [23:0] rel_end_ff, rel_end_in;
   logic [14:0] smp_len_ff, smp_len_in;

   logic [wvir_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [wvir_pkg::CNT_W-1:0] elapsed_ff, elapsed_in;
   logic                       voice_on_ff, voice_on_in;

   logic               a_ok_ff, a_ok_in;
   logic               b_ok_ff, b_ok_in;
   logic signed [7:0]  a_ff, a_in;
   logic signed [18:0] interp_ff, interp_in;
   logic signed [25:0] prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic [14:0]        vnum_ff, vnum_in;
   logic [8:0]         vmag_ff, vmag_in;
   logic [10:0]        g_ff, g_in;
   wvir_pkg::rsp_type  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wvir_pkg::rsp_type  rsp_ff, rsp_in;

   wvir_pkg::div_cmd_type  div_cmd;
   wvir_pkg::div_stat_type div_stat;

   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic               req_fire;
   logic [15:0]        idx;
   logic [16:0]        idx_b;
   logic [9:0]         frac;
   logic signed [7:0]  b_val;
   logic signed [8:0]  diff;
   logic signed [19:0] dprod;
   logic signed [27:0] pmul;
   logic [25:0]        pabs;
   logic [27:0]        vrec;
   logic [23:0]        span;
   logic [19:0]        fmul;
   logic [9:0]         mag;
   logic [7:0]         sat;
   logic [wvir_pkg::POS_W-1:0] pos_nx;
   logic [wvir_pkg::CNT_W-1:0] el_nx;
   logic               out_free;

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign idx   = pos_ff[wvir_pkg::POS_W-1:wvir_pkg::FRAC_BITS];
   assign idx_b = {1'b0, idx} + 17'd1;
   assign frac  = pos_ff[wvir_pkg::FRAC_BITS-1:0];

   assign ram_we = req_fire && req_payload.kind == wvir_pkg::KIND_WRITE &&
                   {3'b000, req_payload.addr} < 17'(WAVE_DEPTH);
   assign ram_raddr = (state_ff == ST_RDA) ? AW'(idx) : AW'(idx_b);

   wvir_wave_ram #(
      .DEPTH (WAVE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_payload.addr)),
      .wr_data (req_payload.byte_req),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wvir_div_unit u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign b_val = b_ok_ff ? $signed(ram_rdata) : 8'sd0;
   assign diff  = {b_val[7], b_val} - {a_ff[7], a_ff};
   assign dprod = diff * $signed({1'b0, frac});
   assign pmul  = interp_ff * $signed({1'b0, volume_ff});
   assign pabs  = prod_ff[25] ? 26'(-prod_ff) : prod_ff;
   assign vrec  = vnum_ff * 13'(wvir_pkg::VOL_RECIP);
   assign span  = elapsed_ff - sustain_ff;
   assign fmul  = vmag_ff * g_ff;
   assign mag   = fmul[19:10];
   assign pos_nx = pos_ff + {2'b00, step_ff};
   assign el_nx  = elapsed_ff + 24'd1;

   always_comb begin
      if (neg_ff) begin
         sat = (mag >= 10'd128) ? 8'h80 : 8'(10'd0 - mag);
      end else begin
         sat = (mag >= 10'd128) ? 8'h7f : mag[7:0];
      end
   end

   always_comb begin
      div_cmd = '0;
      if (state_ff == ST_FADE && span < rel_len_ff) begin
         div_cmd.start    = 1'b1;
         div_cmd.rem_init = {1'b0, span};
         div_cmd.low_bits = '0;
         div_cmd.divisor  = {1'b0, rel_len_ff};
         div_cmd.steps    = 4'd10;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      volume_in    = volume_ff;
      sustain_in   = sustain_ff;
      rel_len_in   = rel_len_ff;
      rel_end_in   = rel_end_ff;
      smp_len_in   = smp_len_ff;
      pos_in       = pos_ff;
      elapsed_in   = elapsed_ff;
      voice_on_in  = voice_on_ff;
      a_ok_in      = a_ok_ff;
      b_ok_in      = b_ok_ff;
      a_in         = a_ff;
      interp_in    = interp_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      vnum_in      = vnum_ff;
      vmag_in      = vmag_ff;
      g_in         = g_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            wvir_pkg::CSR_STEP:        step_in    = csr_wdata;
            wvir_pkg::CSR_VOLUME:      volume_in  = csr_wdata[7:0];
            wvir_pkg::CSR_SUSTAIN_LEN: sustain_in = csr_wdata;
            wvir_pkg::CSR_RELEASE_LEN: rel_len_in = csr_wdata;
            wvir_pkg::CSR_RELEASE_END: rel_end_in = csr_wdata;
            wvir_pkg::CSR_SAMPLE_LEN:  smp_len_in = csr_wdata[14:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.kind == wvir_pkg::KIND_START) begin
                  pos_in      = '0;
                  elapsed_in  = '0;
                  voice_on_in = 1'b1;
               end else if (req_payload.kind == wvir_pkg::KIND_TICK && voice_on_ff) begin
                  state_in = ST_RDA;
               end
            end
         end
         ST_RDA: begin
            a_ok_in  = ({1'b0, idx} < {2'b00, smp_len_ff}) &&
                       ({1'b0, idx} < 17'(WAVE_DEPTH));
            b_ok_in  = (idx_b < {2'b00, smp_len_ff}) && (idx_b < 17'(WAVE_DEPTH));
            state_in = ST_RDB;
         end
         ST_RDB: begin
            a_in     = a_ok_ff ? $signed(ram_rdata) : 8'sd0;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            interp_in = 19'(dprod) + {a_ff[7], a_ff, 10'b0};
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = pmul[25:0];
            state_in = ST_VSTRT;
         end
         ST_VSTRT: begin
            neg_in   = prod_ff[25];
            vnum_in  = pabs[24:10];
            state_in = ST_VWAIT;
         end
         ST_VWAIT: begin
            vmag_in = 9'(vrec >> wvir_pkg::VOL_RECIP_SH);
            if (elapsed_ff >= sustain_ff) begin
               state_in = ST_FADE;
            end else begin
               g_in     = 11'(wvir_pkg::ONE_FIX);
               state_in = ST_APPLY;
            end
         end
         ST_FADE: begin
            if (span < rel_len_ff) begin
               state_in = ST_FWAIT;
            end else begin
               g_in     = '0;
               state_in = ST_APPLY;
            end
         end
         ST_FWAIT: begin
            if (!div_stat.busy) begin
               g_in     = 11'(wvir_pkg::ONE_FIX) - {1'b0, div_stat.quot};
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            res_in.sample = sat;
            res_in.last   = (pos_nx >= {1'b0, smp_len_ff, 10'b0}) || (el_nx >= rel_end_ff);
            pos_in        = pos_nx;
            elapsed_in    = el_nx;
            if (res_in.last) begin
               voice_on_in = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 24'd1024;
         volume_ff    <= 8'd100;
         sustain_ff   <= 24'd0;
         rel_len_ff   <= 24'd1;
         rel_end_ff   <= 24'd1;
         smp_len_ff   <= 15'd0;
         pos_ff       <= '0;
         elapsed_ff   <= '0;
         voice_on_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         volume_ff    <= volume_in;
         sustain_ff   <= sustain_in;
         rel_len_ff   <= rel_len_in;
         rel_end_ff   <= rel_end_in;
         smp_len_ff   <= smp_len_in;
         pos_ff       <= pos_in;
         elapsed_ff   <= elapsed_in;
         voice_on_ff  <= voice_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ok_ff   <= a_ok_in;
      b_ok_ff   <= b_ok_in;
      a_ff      <= a_in;
      interp_ff <= interp_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      vnum_ff   <= vnum_in;
      vmag_ff   <= vmag_in;
      g_ff      <= g_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== bench/wavetable_voice_interp_release_tb.sv =====
// ---------------------------------------------------------------------------
// Wavetable voice testbench
// Drives write, start, tick and unused-kind requests into the voice under
// random idling on both channels. A scoreboard class keeps its own wavetable
// and voice state, predicts each sample transfer and compares the results in
// order. Register settings change between phases, with the block drained.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module wavetable_voice_interp_release_tb;
   import wvir_pkg::*;

   localparam int WAVE_DEPTH = WAVE_DEPTH_DEF;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int unsigned MAX24 = 24'hFFFFFF;
   localparam int ITEMS = 400;
   localparam int SETTLE = 40;
   localparam int HOLD_CYCLES = 300;

   class voice_scoreboard;
      byte wave_mem [WAVE_DEPTH];
      bit wave_set [WAVE_DEPTH];
      logic [POS_W-1:0] position = '0;
      logic [CNT_W-1:0] tick_count = '0;
      logic playing = 1'b0;
      logic [23:0] pitch_step = 24'd1024;
      logic [7:0] volume = 8'd100;
      logic [23:0] sustain_len = '0;
      logic [23:0] release_len = 24'd1;
      logic [23:0] release_end = 24'd1;
      logic [14:0] sample_len = '0;
      rsp_type due_samples [$];
      int errors = 0;

      function void set_reg(logic [2:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_STEP: pitch_step = val;
            CSR_VOLUME: volume = val[7:0];
            CSR_SUSTAIN_LEN: sustain_len = val;
            CSR_RELEASE_LEN: release_len = val;
            CSR_RELEASE_END: release_end = val;
            CSR_SAMPLE_LEN: sample_len = val[14:0];
            default: ;
         endcase
      endfunction

      function int tap(int idx);
         if (idx >= sample_len || idx >= WAVE_DEPTH) return 0;
         return wave_mem[idx];
      endfunction

      // Returns a table entry that the next tick would read but that holds no
      // byte yet, or -1 when the tick is safe to send.
      function int missing_byte();
         int idx;
         if (!playing) return -1;
         idx = int'(position >> FRAC_BITS);
         for (int k = idx; k <= idx + 1; k++) begin
            if (k < WAVE_DEPTH && !wave_set[k]) return k;
         end
         return -1;
      endfunction

      function void note_request(req_type r);
         int idx;
         int frac;
         int acc;
         int gain;
         longint drop;
         logic done;
         rsp_type want;
         case (r.kind)
            KIND_WRITE: begin
               if (r.addr < WAVE_DEPTH) begin
                  wave_mem[r.addr] = r.byte_req;
                  wave_set[r.addr] = 1'b1;
               end
            end
            KIND_START: begin
               position = '0;
               tick_count = '0;
               playing = 1'b1;
            end
            KIND_TICK: if (playing) begin
               idx = int'(position >> FRAC_BITS);
               frac = int'(position) & (ONE_FIX - 1);
               acc = (tap(idx) * (ONE_FIX - frac) + tap(idx + 1) * frac) * int'(volume);
               acc = acc / VOL_DIV;
               if (tick_count >= sustain_len) begin
                  if (release_len == 0) begin
                     gain = 0;
                  end else begin
                     drop = (longint'(tick_count - sustain_len) << FRAC_BITS)
                            / longint'(release_len);
                     gain = (drop >= ONE_FIX) ? 0 : ONE_FIX - int'(drop);
                  end
                  acc = acc * gain / ONE_FIX;
               end
               position = position + pitch_step;
               tick_count = tick_count + 1'b1;
               done = (position >= (27'(sample_len) << FRAC_BITS)) ||
                      (tick_count >= release_end);
               if (done) playing = 1'b0;
               if (acc > 127) acc = 127;
               else if (acc < -128) acc = -128;
               want.sample = acc[7:0];
               want.last = done;
               due_samples.push_back(want);
            end
            default: ;
         endcase
      endfunction

      function void check_sample(rsp_type got);
         rsp_type want;
         if (due_samples.size() == 0) begin
            $display("%0t: expected no sample, got sample %0d last %0b",
                     $time, got.sample, got.last);
            errors++;
            return;
         end
         want = due_samples.pop_front();
         if (got.sample !== want.sample) begin
            $display("%0t: sample expected %0d, got %0d", $time, want.sample, got.sample);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = CSR_STEP;
   logic [CSR_W-1:0] csr_wdata = '0;

   logic calm = 1'b0;
   logic hold_go = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   int item_cnt = 0;

   voice_scoreboard sb = new;

   wavetable_voice_interp_release #(
      .WAVE_DEPTH(WAVE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver checks each sample transfer and then picks its next ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_sample(rsp_payload);
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
      end
   end

   task automatic offer(input req_type r);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      item_cnt++;
   endtask

   // A tick first fills any table entry it would read that was never written.
   task automatic send(input logic [1:0] kind, input int addr, input int data);
      req_type r;
      int k;
      if (kind == KIND_TICK) begin
         k = sb.missing_byte();
         while (k >= 0) begin
            r.kind = KIND_WRITE;
            r.addr = 14'(k);
            r.byte_req = 8'($urandom);
            offer(r);
            k = sb.missing_byte();
         end
      end
      r.kind = kind;
      r.addr = 14'(addr);
      r.byte_req = data[7:0];
      offer(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.due_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic reg_write(input logic [2:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      @(posedge clock);
      sb.set_reg(idx, val[CSR_W-1:0]);
   endtask

   task automatic set_regs(input int unsigned stp, vol, sus, rlen, rend, slen);
      reg_write(CSR_STEP, stp);
      reg_write(CSR_VOLUME, vol);
      reg_write(CSR_SUSTAIN_LEN, sus);
      reg_write(CSR_RELEASE_LEN, rlen);
      reg_write(CSR_RELEASE_END, rend);
      reg_write(CSR_SAMPLE_LEN, slen);
      csr_we <= 1'b0;
   endtask

   function automatic int unsigned draw_value(int unsigned typ_hi, int unsigned top);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return top;
         2: return $urandom_range(0, top);
         default: return $urandom_range(0, typ_hi);
      endcase
   endfunction

   task automatic run_phase(input int n);
      int roll;
      int addr_hi;
      logic [1:0] kind;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         addr_hi = (sb.sample_len == 0) ? 0 : int'(sb.sample_len) - 1;
         if ((!sb.playing && roll < 60) || roll < 6) begin
            kind = KIND_START;
         end else if (roll < 18) begin
            kind = KIND_WRITE;
         end else if (roll < 22) begin
            kind = KIND_WRITE;
            addr_hi = WAVE_DEPTH - 1;
         end else if (roll < 25) begin
            kind = KIND_NONE;
         end else begin
            kind = KIND_TICK;
         end
         send(kind, $urandom_range(0, addr_hi), $urandom);
      end
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send(KIND_WRITE, 0, 127);
      send(KIND_WRITE, 1, -128);
      send(KIND_WRITE, 2, 85);
      send(KIND_WRITE, 3, -86);
      send(KIND_NONE, 16383, -1);
      send(KIND_START, 0, 0);
      send(KIND_TICK, 0, 0);

      drain();
      set_regs(512, 100, 2, 4, 8, 4);
      send(KIND_START, 0, 0);
      send(KIND_TICK, 0, 0);
      send(KIND_TICK, 0, 0);
      send(KIND_START, 0, 0);
      send(KIND_TICK, 0, 0);
      send(KIND_WRITE, 2, -1);
      while (sb.playing) send(KIND_TICK, 0, 0);
      send(KIND_TICK, 0, 0);

      drain();
      set_regs(1024, 255, MAX24, 0, MAX24, 4);
      send(KIND_START, 0, 0);
      while (sb.playing) send(KIND_TICK, 0, 0);

      drain();
      set_regs(MAX24, 200, 1, 0, MAX24, 16384);
      send(KIND_START, 0, 0);
      while (sb.playing) send(KIND_TICK, 0, 0);

      drain();
      set_regs(0, 0, 0, MAX24, 0, 1);
      send(KIND_START, 0, 0);
      send(KIND_TICK, 0, 0);

      phase = 0;
      while (item_cnt < ITEMS) begin
         drain();
         calm <= (phase == 2);
         if (phase == 4) begin
            // The receiver stalls for a long stretch while ticks keep coming.
            hold_go <= 1'b1;
            set_regs(256, 100, MAX24, 1, MAX24, 64);
            send(KIND_START, 0, 0);
            run_phase(80);
         end else begin
            set_regs(draw_value(3072, MAX24), draw_value(255, 255), draw_value(20, MAX24),
                     draw_value(30, MAX24), draw_value(60, MAX24), draw_value(64, 16384));
            run_phase($urandom_range(20, 60));
         end
         phase++;
      end

      drain();
      if (sb.errors == 0 && sb.due_samples.size() == 0) begin
         $display("** wavetable_voice_interp_release: PASSED **");
      end else begin
         $display("** wavetable_voice_interp_release: FAILED **");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("** wavetable_voice_interp_release: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/wvir_pkg.sv
sv/wvir_wave_ram.sv
sv/wvir_div_unit.sv
sv/wavetable_voice_interp_release.sv
bench/wavetable_voice_interp_release_tb.sv
